// File: hw/rtl/length_prefixed_frame_decoder_defines.svh
// ----------------------------------------------------------------------------
// length prefixed frame decoder assertion macros
// shared assertion forms for the decoder checker
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_FRAME_DECODER_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_DECODER_DEFINES_SVH

// same-cycle implication
`define LPFD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lpfd assertion failed");

// next-cycle implication
`define LPFD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lpfd assertion failed");

`endif

// File: hw/rtl/lpfd_pkg.sv
// ----------------------------------------------------------------------------
// lpfd_pkg
// types and codes shared by the length prefixed frame decoder
// ----------------------------------------------------------------------------
package lpfd_pkg;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_TYPE    = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;
  localparam logic [1:0] PH_ERROR   = 2'd3;

  localparam logic [1:0] KIND_TYPE    = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_ZERO_LEN = 2'd1;
  localparam logic [1:0] ERR_TOO_BIG  = 2'd2;

  // count value of the fourth length word
  localparam logic [1:0] HEADER_LAST = 2'd3;

  localparam logic [31:0] MAX_FRAME_RESET = 32'd65536;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       last;
    logic [1:0] error_code;
  } lpfd_result_t;

endpackage

// File: hw/rtl/length_prefixed_frame_decoder.sv
// ----------------------------------------------------------------------------
// length_prefixed_frame_decoder
// deframes a byte stream of 32-bit big-endian length prefixed frames
// ----------------------------------------------------------------------------
// Takes one stream word per cycle while the output side keeps taking results.
// A word is held in the input register while it is decoded, and its result is
// captured in the output register. The frame state update (length shift,
// remaining count decrement, one 32-bit compare against max_frame_size) is
// done per word and sets that rate. A held result also holds the decode
// stage, header words included: the input register takes one more word, and
// then in_ready stays low until the result is taken. Header words give no
// result; a zero or oversize length gives one error report, after which all
// words are dropped until reset. cfg_ready is always high.
module length_prefixed_frame_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  data_byte,
  output logic        last,
  output logic [1:0]  error_code
);
  import lpfd_pkg::*;

  logic         advance;
  logic         s1_valid;
  logic [7:0]   s1_byte;
  lpfd_result_t res;

  assign cfg_ready = 1'b1;

  lpfd_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_byte  (s1_byte)
  );

  lpfd_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .step     (s1_valid && advance),
    .in_byte  (s1_byte),
    .res      (res)
  );

  lpfd_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .res        (res),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .data_byte  (data_byte),
    .last       (last),
    .error_code (error_code)
  );

endmodule

// File: hw/rtl/lpfd_in_reg.sv
// ----------------------------------------------------------------------------
// lpfd_in_reg
// input register holding one received word for the decode stage
// ----------------------------------------------------------------------------
module lpfd_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       advance,
  output logic       s1_valid,
  output logic [7:0] s1_byte
);
  import lpfd_pkg::*;

  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= in_byte;
    end
  end

endmodule

// File: hw/rtl/lpfd_core.sv
// ----------------------------------------------------------------------------
// lpfd_core
// deframing state and per-word decode with the maximum length register
// ----------------------------------------------------------------------------
module lpfd_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [31:0]           cfg_data,
  input  logic                  step,
  input  logic [7:0]            in_byte,
  output lpfd_pkg::lpfd_result_t res
);
  import lpfd_pkg::*;

  logic [1:0]  phase, phase_next;
  logic [1:0]  header_count, header_count_next;
  logic [31:0] length_accum, length_accum_next;
  logic [31:0] bytes_left, bytes_left_next;
  logic [31:0] max_frame_size;
  logic [31:0] acc_shift;
  logic [31:0] left_dec;
  lpfd_result_t res_c;

  assign acc_shift = {length_accum[23:0], in_byte};
  assign left_dec  = bytes_left - 32'd1;

  always_comb begin
    phase_next        = phase;
    header_count_next = header_count;
    length_accum_next = length_accum;
    bytes_left_next   = bytes_left;
    res_c             = '0;
    unique case (phase) inside
      PH_HEADER: begin
        length_accum_next = acc_shift;
        header_count_next = header_count + 2'd1;
        if (header_count == HEADER_LAST) begin
          if (acc_shift == 32'd0) begin
            phase_next       = PH_ERROR;
            res_c.valid      = 1'b1;
            res_c.kind       = KIND_ERROR;
            res_c.error_code = ERR_ZERO_LEN;
          end else if (acc_shift > max_frame_size) begin
            phase_next       = PH_ERROR;
            res_c.valid      = 1'b1;
            res_c.kind       = KIND_ERROR;
            res_c.error_code = ERR_TOO_BIG;
          end else begin
            bytes_left_next = acc_shift;
            phase_next      = PH_TYPE;
          end
        end
      end
      PH_TYPE, PH_PAYLOAD: begin
        bytes_left_next  = left_dec;
        res_c.valid      = 1'b1;
        res_c.kind       = (phase == PH_TYPE) ? KIND_TYPE : KIND_PAYLOAD;
        res_c.data_byte  = in_byte;
        res_c.last       = (left_dec == 32'd0);
        res_c.error_code = ERR_NONE;
        if (left_dec == 32'd0) begin
          phase_next        = PH_HEADER;
          header_count_next = 2'd0;
          length_accum_next = 32'd0;
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
      default: begin
        // sticky error, word dropped
      end
    endcase
  end

  always_comb begin
    res       = res_c;
    res.valid = res_c.valid && step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      header_count   <= 2'd0;
      length_accum   <= 32'd0;
      bytes_left     <= 32'd0;
      max_frame_size <= MAX_FRAME_RESET;
    end else begin
      if (step) begin
        phase        <= phase_next;
        header_count <= header_count_next;
        length_accum <= length_accum_next;
        bytes_left   <= bytes_left_next;
      end
      if (cfg_we) begin
        max_frame_size <= cfg_data;
      end
    end
  end

endmodule

// File: hw/rtl/lpfd_out_reg.sv
// ----------------------------------------------------------------------------
// lpfd_out_reg
// result register facing the output channel
// ----------------------------------------------------------------------------
module lpfd_out_reg (
  input  logic                  clk,
  input  logic                  rst,
  input  lpfd_pkg::lpfd_result_t res,
  output logic                  advance,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            kind,
  output logic [7:0]            data_byte,
  output logic                  last,
  output logic [1:0]            error_code
);
  import lpfd_pkg::*;

  assign advance = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      kind       <= res.kind;
      data_byte  <= res.data_byte;
      last       <= res.last;
      error_code <= res.error_code;
    end
  end

endmodule

// File: hw/rtl/lpfd_checker.sv
// ----------------------------------------------------------------------------
// lpfd_checker
// port-level checks on the decoder output channel
// ----------------------------------------------------------------------------
`include "length_prefixed_frame_decoder_defines.svh"

module lpfd_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] kind,
  input logic [7:0] data_byte,
  input logic       last,
  input logic [1:0] error_code
);
  import lpfd_pkg::*;

  // stalled result holds
  `LPFD_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(kind) && $stable(data_byte) && $stable(last) && $stable(error_code))

  // error report carries a code and nothing else
  `LPFD_ASSERT_IMP(a_err_fields, clk, rst, out_valid && kind == KIND_ERROR, (error_code == ERR_ZERO_LEN || error_code == ERR_TOO_BIG) && data_byte == 8'd0 && !last)

  // data results carry no error code
  `LPFD_ASSERT_IMP(a_data_no_err, clk, rst, out_valid && kind != KIND_ERROR, error_code == ERR_NONE && (kind == KIND_TYPE || kind == KIND_PAYLOAD))

  // error is sticky: nothing follows a taken error report
  `LPFD_ASSERT_NXT(a_err_sticky, clk, rst, out_valid && out_ready && kind == KIND_ERROR, !out_valid)

endmodule

bind length_prefixed_frame_decoder lpfd_checker u_lpfd_checker (.*);
